[rtl/core/smcd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and control types of the strip mean color descriptor unit.
package smcd_pkg;

	localparam int MAX_STRIPS = 16;
	localparam int STRIP_W    = 4;
	localparam int NSTRIP_W   = 5;
	localparam int DIV_W      = 48;
	localparam int STEP_W     = 6;
	localparam int Q_ONE      = 16384;

	localparam logic [2:0] MODE_PIXEL   = 3'd0;
	localparam logic [2:0] MODE_EOF     = 3'd1;
	localparam logic [2:0] MODE_HEADING = 3'd2;
	localparam logic [2:0] MODE_VEL     = 3'd3;
	localparam logic [2:0] MODE_YAW     = 3'd4;
	localparam logic [2:0] MODE_TICK    = 3'd5;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_STRIPS = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	localparam logic [1:0] DIV_STRIP = 2'd0;
	localparam logic [1:0] DIV_TICK  = 2'd1;
	localparam logic [1:0] DIV_MEAN  = 2'd2;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_LAST  = 2'd3;

	typedef struct packed {
		logic [31:0] sum_red;
		logic [31:0] sum_green;
		logic [31:0] sum_blue;
		logic [24:0] count;
	} entry_t;

	typedef struct packed {
		logic       cap;
		logic       eof;
		logic       set_head;
		logic       set_vel;
		logic       set_yaw;
		logic       div_start;
		logic [1:0] div_sel;
		logic       pix_write;
		logic       el_clear;
		logic       el_next;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic tick_hit;
		logic pose;
		logic count_zero;
		logic last_el;
		logic out_free;
	} status_t;

endpackage

[rtl/core/smcd_divider.sv]
`timescale 1ns / 1ps
// Shared restoring divider that produces one quotient bit per cycle.
module smcd_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [smcd_pkg::DIV_W-1:0]     rem_in,
	input  logic [smcd_pkg::DIV_W-1:0]     dsh_in,
	input  logic [smcd_pkg::STEP_W-1:0]    steps_in,
	output logic                           busy,
	output logic [15:0]                    quo,
	output logic [smcd_pkg::DIV_W-1:0]     rem
);

	logic [smcd_pkg::DIV_W-1:0]  rem_q;
	logic [smcd_pkg::DIV_W-1:0]  dsh_q;
	logic [15:0]                 quo_q;
	logic [smcd_pkg::STEP_W-1:0] steps_q;
	logic                        ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= steps_in;
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_in;
			dsh_q <= dsh_in;
			quo_q <= '0;
		end else if (steps_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[14:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = steps_q != '0;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/core/smcd_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration, strip accumulator banks, pose registers, divider operands and output register.
module smcd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smcd_pkg::cmd_t       cmd,
	output smcd_pkg::status_t    status,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [11:0]          column,
	input  logic signed [15:0]   heading_sin,
	input  logic signed [15:0]   heading_cos,
	input  logic signed [15:0]   rate_value,
	input  logic [31:0]          tick_number,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [5:0]           element_index,
	output logic signed [15:0]   value,
	output logic [31:0]          tick_echo,
	output logic                 last
);

	logic [12:0] width_q;
	logic [4:0]  strips_q;
	logic [15:0] period_q;

	logic [12:0] w_eff;
	logic [4:0]  n_eff;
	logic [15:0] per_eff;

	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [11:0] col_q;
	logic [31:0] tick_q;

	logic signed [15:0] hsin_q;
	logic signed [15:0] hcos_q;
	logic signed [15:0] vel_q;
	logic signed [15:0] yaw_q;

	smcd_pkg::entry_t bank_q [2][smcd_pkg::MAX_STRIPS];
	logic [1:0][smcd_pkg::MAX_STRIPS-1:0] vld_q;
	logic sel_q;

	logic [smcd_pkg::NSTRIP_W-1:0] strip_q;
	logic [1:0]                    chan_q;
	logic                          big_q;

	logic                         out_valid_q;
	logic [5:0]                   index_q;
	logic signed [15:0]           value_q;
	logic [31:0]                  echo_q;
	logic                         last_q;

	logic                          div_busy;
	logic [15:0]                   div_quo;
	logic [smcd_pkg::DIV_W-1:0]    div_rem;
	logic [smcd_pkg::DIV_W-1:0]    rem_in;
	logic [smcd_pkg::DIV_W-1:0]    dsh_in;
	logic [smcd_pkg::STEP_W-1:0]   steps_in;

	logic                          clamp;
	logic [smcd_pkg::STRIP_W-1:0]  pix_strip;
	smcd_pkg::entry_t              work_ent;
	smcd_pkg::entry_t              work_new;
	smcd_pkg::entry_t              held_ent;
	logic [31:0]                   held_sum;
	logic [32:0]                   den;
	logic [15:0]                   prod;
	logic                          pose;
	logic [14:0]                   mean_sat;
	logic signed [15:0]            pose_val;
	logic signed [15:0]            el_val;
	logic signed [19:0]            vel_x;
	logic signed [20:0]            yaw_x;
	logic [5:0]                    el_index;

	always_comb begin
		w_eff   = (width_q == '0) ? 13'd1 : width_q;
		per_eff = (period_q == '0) ? 16'd1 : period_q;
		if (strips_q == '0) begin
			n_eff = 5'd1;
		end else if (strips_q > 5'(smcd_pkg::MAX_STRIPS)) begin
			n_eff = 5'(smcd_pkg::MAX_STRIPS);
		end else begin
			n_eff = strips_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			strips_q <= 5'd6;
			period_q <= 16'd15;
		end else if (cfg_write) begin
			unique case (cfg_index)
				smcd_pkg::REG_WIDTH:  width_q  <= cfg_data[12:0];
				smcd_pkg::REG_STRIPS: strips_q <= cfg_data[4:0];
				smcd_pkg::REG_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			col_q   <= column;
			tick_q  <= tick_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsin_q <= '0;
			hcos_q <= '0;
			vel_q  <= '0;
			yaw_q  <= '0;
		end else begin
			if (cmd.set_head) begin
				hsin_q <= heading_sin;
				hcos_q <= heading_cos;
			end
			if (cmd.set_vel) begin
				vel_q <= rate_value;
			end
			if (cmd.set_yaw) begin
				yaw_q <= rate_value;
			end
		end
	end

	assign clamp     = {1'b0, col_q} >= w_eff;
	assign pix_strip = clamp ? 4'(n_eff - 5'd1) : div_quo[3:0];

	always_comb begin
		work_ent = vld_q[sel_q][pix_strip] ? bank_q[sel_q][pix_strip] : '0;
		work_new.sum_red   = work_ent.sum_red + 32'(red_q);
		work_new.sum_green = work_ent.sum_green + 32'(green_q);
		work_new.sum_blue  = work_ent.sum_blue + 32'(blue_q);
		work_new.count     = work_ent.count + 25'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_write) begin
			bank_q[sel_q][pix_strip] <= work_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			sel_q <= 1'b0;
		end else if (cmd.eof) begin
			sel_q         <= ~sel_q;
			vld_q[~sel_q] <= '0;
		end else if (cmd.pix_write) begin
			vld_q[sel_q][pix_strip] <= 1'b1;
		end
	end

	assign pose     = strip_q == n_eff;
	assign held_ent = vld_q[~sel_q][strip_q[3:0]] ? bank_q[~sel_q][strip_q[3:0]] : '0;

	always_comb begin
		case (chan_q)
			smcd_pkg::CH_RED:   held_sum = held_ent.sum_red;
			smcd_pkg::CH_GREEN: held_sum = held_ent.sum_green;
			default:            held_sum = held_ent.sum_blue;
		endcase
	end

	assign den  = {held_ent.count, 8'd0} - 33'(held_ent.count);
	assign prod = 16'(col_q) * 16'(n_eff);

	always_comb begin
		unique case (cmd.div_sel)
			smcd_pkg::DIV_STRIP: begin
				rem_in   = 48'(prod);
				dsh_in   = 48'({w_eff, 3'd0});
				steps_in = 6'd4;
			end
			smcd_pkg::DIV_TICK: begin
				rem_in   = 48'(tick_q);
				dsh_in   = {1'b0, per_eff, 31'd0};
				steps_in = 6'd32;
			end
			default: begin
				rem_in   = {2'b0, held_sum, 14'd0};
				dsh_in   = {1'b0, den, 14'd0};
				steps_in = 6'd15;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			big_q <= {2'b0, held_sum, 14'd0} >= {den, 15'd0};
		end
	end

	smcd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_in   (rem_in),
		.dsh_in   (dsh_in),
		.steps_in (steps_in),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= '0;
			chan_q  <= '0;
		end else if (cmd.el_clear) begin
			strip_q <= '0;
			chan_q  <= '0;
		end else if (cmd.el_next) begin
			if (!pose && chan_q == smcd_pkg::CH_BLUE) begin
				strip_q <= strip_q + 1'b1;
				chan_q  <= '0;
			end else begin
				chan_q <= chan_q + 1'b1;
			end
		end
	end

	assign vel_x = 20'(vel_q) <<< 4;
	assign yaw_x = 21'(yaw_q) <<< 5;

	always_comb begin
		case (chan_q)
			smcd_pkg::CH_RED:   pose_val = hsin_q;
			smcd_pkg::CH_GREEN: pose_val = hcos_q;
			smcd_pkg::CH_BLUE: begin
				if (vel_x > 20'sd16384) begin
					pose_val = 16'sd16384;
				end else if (vel_x < -20'sd16384) begin
					pose_val = -16'sd16384;
				end else begin
					pose_val = 16'(vel_x);
				end
			end
			default: begin
				if (yaw_x > 21'sd16384) begin
					pose_val = 16'sd16384;
				end else if (yaw_x < -21'sd16384) begin
					pose_val = -16'sd16384;
				end else begin
					pose_val = 16'(yaw_x);
				end
			end
		endcase
	end

	assign mean_sat = (big_q || div_quo[14:0] > 15'(smcd_pkg::Q_ONE)) ?
		15'(smcd_pkg::Q_ONE) : div_quo[14:0];

	always_comb begin
		if (pose) begin
			el_val = pose_val;
		end else if (held_ent.count == '0) begin
			el_val = '0;
		end else begin
			el_val = 16'(mean_sat);
		end
	end

	assign el_index = (6'(strip_q) * 6'd3) + 6'(chan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			index_q <= el_index;
			value_q <= el_val;
			echo_q  <= tick_q;
			last_q  <= pose && chan_q == smcd_pkg::CH_LAST;
		end
	end

	assign status.div_busy   = div_busy;
	assign status.tick_hit   = div_rem == '0;
	assign status.pose       = pose;
	assign status.count_zero = held_ent.count == '0;
	assign status.last_el    = pose && chan_q == smcd_pkg::CH_LAST;
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign element_index = index_q;
	assign value         = value_q;
	assign tick_echo     = echo_q;
	assign last          = last_q;

endmodule

[rtl/core/smcd_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine that sequences pixel updates, tick checks and descriptor emission.
module smcd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [2:0]           mode,
	input  smcd_pkg::status_t    status,
	output logic                 in_stall,
	output smcd_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_PIX_START  = 3'd1;
	localparam logic [2:0] ST_PIX_WAIT   = 3'd2;
	localparam logic [2:0] ST_TICK_START = 3'd3;
	localparam logic [2:0] ST_TICK_WAIT  = 3'd4;
	localparam logic [2:0] ST_EL_PREP    = 3'd5;
	localparam logic [2:0] ST_EL_WAIT    = 3'd6;
	localparam logic [2:0] ST_EL_LOAD    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					case (mode)
						smcd_pkg::MODE_PIXEL:   state_d = ST_PIX_START;
						smcd_pkg::MODE_EOF:     cmd.eof = 1'b1;
						smcd_pkg::MODE_HEADING: cmd.set_head = 1'b1;
						smcd_pkg::MODE_VEL:     cmd.set_vel = 1'b1;
						smcd_pkg::MODE_YAW:     cmd.set_yaw = 1'b1;
						smcd_pkg::MODE_TICK:    state_d = ST_TICK_START;
						default: ;
					endcase
				end
			end
			ST_PIX_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = smcd_pkg::DIV_STRIP;
				state_d       = ST_PIX_WAIT;
			end
			ST_PIX_WAIT: begin
				if (!status.div_busy) begin
					cmd.pix_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_TICK_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = smcd_pkg::DIV_TICK;
				state_d       = ST_TICK_WAIT;
			end
			ST_TICK_WAIT: begin
				if (!status.div_busy) begin
					if (status.tick_hit) begin
						cmd.el_clear = 1'b1;
						state_d      = ST_EL_PREP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EL_PREP: begin
				if (status.pose || status.count_zero) begin
					state_d = ST_EL_LOAD;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = smcd_pkg::DIV_MEAN;
					state_d       = ST_EL_WAIT;
				end
			end
			ST_EL_WAIT: begin
				cmd.div_sel = smcd_pkg::DIV_MEAN;
				if (!status.div_busy) begin
					state_d = ST_EL_LOAD;
				end
			end
			ST_EL_LOAD: begin
				cmd.div_sel = smcd_pkg::DIV_MEAN;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.last_el) begin
						state_d = ST_IDLE;
					end else begin
						cmd.el_next = 1'b1;
						state_d     = ST_EL_PREP;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/strip_mean_color_descriptor_unit.sv]
`timescale 1ns / 1ps
// Top level of the strip mean color descriptor unit.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     mode, red, green, blue, column, heading_sin,
//                                    heading_cos, rate_value, tick_number
//   out      out_valid / out_stall   element_index, value, tick_echo, last
//   cfg      cfg_write               cfg_index, cfg_data
//
// Heading, velocity, yaw, end-of-frame and unused modes are done as they are accepted.
// A pixel waits on the four-step shared divider, which gives its strip index.
// A tick runs a 32-step modulo check of tick_number by the period; an emitting tick
// then runs the 15-step divider for each non-empty strip mean, and pose values skip it.
// One transaction is in work at a time; out_stall holds the output register and the
// sequence. Reset restores the register defaults and clears all sums and pose values.
module strip_mean_color_descriptor_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          mode,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [11:0]         column,
	input  logic signed [15:0]  heading_sin,
	input  logic signed [15:0]  heading_cos,
	input  logic signed [15:0]  rate_value,
	input  logic [31:0]         tick_number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [5:0]          element_index,
	output logic signed [15:0]  value,
	output logic [31:0]         tick_echo,
	output logic                last,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	smcd_pkg::cmd_t    cmd;
	smcd_pkg::status_t status;

	smcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	smcd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.column        (column),
		.heading_sin   (heading_sin),
		.heading_cos   (heading_cos),
		.rate_value    (rate_value),
		.tick_number   (tick_number),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.element_index (element_index),
		.value         (value),
		.tick_echo     (tick_echo),
		.last          (last)
	);

endmodule
